[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/asm_pkg.sv]
package asm_pkg;

	localparam int SYM_W  = 21;
	localparam int DIST_W = 6;
	localparam int OPOS_W = 16;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_START  = 2'd2,
		KIND_TEXT   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [SYM_W-1:0]  symbol;
	} item_t;

	typedef struct packed {
		logic [OPOS_W-1:0] begin_pos;
		logic [OPOS_W-1:0] end_pos;
		logic [DIST_W-1:0] edit_distance;
	} result_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_START = 2'd1,
		OP_TEXT  = 2'd2
	} op_t;

	// controller -> datapath
	typedef struct packed {
		op_t  op;
		logic accept;
		logic issue;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic              out_free;
		logic [DIST_W-1:0] max_distance;
	} status_t;

endpackage

[src/asm_ctrl.sv]
module asm_ctrl #(
	parameter int MAX_PATTERN = 32,
	parameter int ROW_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  asm_pkg::kind_t   item_kind,
	output logic             item_stall,
	input  asm_pkg::status_t status,
	output asm_pkg::cmd_t    cmd,
	output logic [ROW_W-1:0] row
);
	import asm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_DONE
	} state_t;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_PATTERN);

	state_t           state_q;
	op_t              op_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);

	always_comb begin
		cmd.op     = op_q;
		cmd.accept = accept;
		cmd.issue  = (state_q == S_SWEEP);
		cmd.finish = (state_q == S_DONE) && (op_q != OP_CLEAR) && status.out_free;
	end
	assign row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			op_q    <= OP_CLEAR;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (item_kind == KIND_START || item_kind == KIND_TEXT)) begin
						op_q    <= (item_kind == KIND_START) ? OP_START : OP_TEXT;
						row_q   <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (row_q == ROW_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (op_q == OP_CLEAR || status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[src/asm_dp.sv]
module asm_dp #(
	parameter int MAX_PATTERN = 32,
	parameter int POS_BITS = 16,
	parameter int ROW_W = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  asm_pkg::item_t                item,
	input  asm_pkg::cmd_t                 cmd,
	input  logic [ROW_W-1:0]              row,
	input  logic                          cfg_valid,
	input  logic [asm_pkg::DIST_W-1:0]    cfg_data,
	output asm_pkg::status_t              status,
	output logic                          result_valid,
	input  logic                          result_stall,
	output asm_pkg::result_t              result
);
	import asm_pkg::*;

	localparam int PI_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [POS_BITS-1:0] bpos;
		logic [DIST_W-1:0]   cost;
	} cell_t;

	function automatic cell_t pick(cell_t a, cell_t b);
		cell_t r;
		if (a.cost < b.cost)      r = a;
		else if (b.cost < a.cost) r = b;
		else                      r = (a.bpos >= b.bpos) ? a : b;
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(logic [ROW_W-1:0] v);
		return (32'(v) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(v);
	endfunction

	logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
	cell_t            bank0 [MAX_PATTERN+1];
	cell_t            bank1 [MAX_PATTERN+1];

	logic [ROW_W-1:0]    len_q;
	logic                sel_q;
	logic [POS_BITS-1:0] tpos_q;
	logic [SYM_W-1:0]    prev_sym_q;
	logic [DIST_W-1:0]   maxd_q;
	logic                out_valid_q;
	result_t             result_q;
	logic [SYM_W-1:0]    sym_q;

	logic                issue_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [SYM_W-1:0]    ps_s1;
	cell_t               rd0_s1, rd1_s1;

	cell_t               prev_now_q, prev_new_q, bef_d1_q, bef_d2_q, bottom_q;
	logic [SYM_W-1:0]    ps_prev_q;

	logic [POS_BITS-1:0] pos_next;
	cell_t               now_rd, bef_rd, m_pair, m_three, m_all, new_cell;
	cell_t               wd0, wd1, start_cell;
	logic                we0, we1, trans_ok, text_match, start_match;

	assign pos_next = (tpos_q == POS_MAX) ? tpos_q : tpos_q + 1'b1;
	assign now_rd   = sel_q ? rd1_s1 : rd0_s1;
	assign bef_rd   = sel_q ? rd0_s1 : rd1_s1;

	// one table row per cycle
	always_comb begin
		m_pair   = pick(prev_now_q, prev_new_q);
		m_three  = pick(now_rd, m_pair);
		trans_ok = (row_s1 > ROW_W'(1)) && (pos_next > POS_BITS'(1))
			&& (ps_s1 == prev_sym_q) && (ps_prev_q == sym_q);
		m_all    = trans_ok ? pick(bef_d2_q, m_three) : m_three;
		if (row_s1 == '0) begin
			new_cell.bpos = pos_next;
			new_cell.cost = '0;
		end else if (row_s1 > len_q) begin
			new_cell = now_rd;
		end else if (ps_s1 == sym_q) begin
			new_cell = prev_now_q;
		end else begin
			new_cell.bpos = m_all.bpos;
			new_cell.cost = (m_all.cost == DIST_MAX) ? DIST_MAX : m_all.cost + 1'b1;
		end
	end

	always_comb begin
		start_cell.bpos = '0;
		start_cell.cost = sat_dist(row_s1);
		wd0 = '0;
		wd1 = '0;
		unique case (cmd.op)
			OP_TEXT: begin
				wd0 = new_cell;
				wd1 = new_cell;
			end
			OP_START: begin
				wd0 = sel_q ? start_cell : cell_t'('0);
				wd1 = sel_q ? cell_t'('0) : start_cell;
			end
			default: begin
				wd0 = '0;
				wd1 = '0;
			end
		endcase
		// text mode writes only the bank that becomes the new column
		we0 = issue_s1 && ((cmd.op != OP_TEXT) || sel_q);
		we1 = issue_s1 && ((cmd.op != OP_TEXT) || !sel_q);
	end

	always_ff @(posedge clk) begin
		if (we0) bank0[row_s1] <= wd0;
		rd0_s1 <= bank0[row];
	end

	always_ff @(posedge clk) begin
		if (we1) bank1[row_s1] <= wd1;
		rd1_s1 <= bank1[row];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.kind == KIND_APPEND && 32'(len_q) < MAX_PATTERN) begin
			pat_mem[len_q[PI_W-1:0]] <= item.symbol;
		end
		ps_s1 <= pat_mem[PI_W'(row - 1'b1)];
	end

	always_ff @(posedge clk) begin
		row_s1 <= row;
		if (cmd.accept) sym_q <= item.symbol;
		if (issue_s1) begin
			prev_now_q <= now_rd;
			prev_new_q <= new_cell;
			bef_d1_q   <= bef_rd;
			bef_d2_q   <= bef_d1_q;
			ps_prev_q  <= ps_s1;
			if (row_s1 == len_q) bottom_q <= new_cell;
		end
	end

	assign text_match  = (bottom_q.cost <= maxd_q);
	assign start_match = (sat_dist(len_q) <= maxd_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd.op == OP_TEXT) begin
				result_q.begin_pos     <= OPOS_W'(32'(bottom_q.bpos));
				result_q.end_pos       <= OPOS_W'(32'(pos_next));
				result_q.edit_distance <= bottom_q.cost;
			end else begin
				result_q.begin_pos     <= '0;
				result_q.end_pos       <= '0;
				result_q.edit_distance <= sat_dist(len_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1    <= 1'b0;
			len_q       <= '0;
			sel_q       <= 1'b0;
			tpos_q      <= '0;
			prev_sym_q  <= '0;
			maxd_q      <= DIST_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			if (cfg_valid) maxd_q <= cfg_data;
			if (cmd.accept && item.kind == KIND_CLEAR) begin
				len_q <= '0;
			end else if (cmd.accept && item.kind == KIND_APPEND
				&& 32'(len_q) < MAX_PATTERN) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.finish) begin
				sel_q <= !sel_q;
				if (cmd.op == OP_TEXT) begin
					tpos_q     <= pos_next;
					prev_sym_q <= sym_q;
				end else begin
					tpos_q     <= '0;
					prev_sym_q <= '0;
				end
			end
			if (cmd.finish && ((cmd.op == OP_TEXT) ? text_match : start_match)) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free     = !out_valid_q || !result_stall;
	assign status.max_distance = maxd_q;
	assign result_valid        = out_valid_q;
	assign result              = result_q;

endmodule

[src/approx_substring_matcher.sv]
// channel   direction  handshake           payload
// item      in         item_valid/stall    asm_pkg::item_t   (kind, symbol)
// result    out        result_valid/stall  asm_pkg::result_t (begin, end, distance)
// cfg       in         cfg_valid/ready     max_distance, 6 bits
//
// Pattern clear and append items need no sweep. Start text and text symbol run
// the row-by-row sweep over the two column memories (one row per cycle, each
// row needs the row above it). After reset a clearing pass zeroes the column
// memories; items stall meanwhile.
// A pending result waits in the output register; a new item is taken meanwhile,
// but a start or text sweep holds in its last cycle until that register frees.
module approx_substring_matcher #(
	parameter int MAX_PATTERN = 32,
	parameter int POS_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  asm_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output asm_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [asm_pkg::DIST_W-1:0] cfg_data
);
	import asm_pkg::*;
	`include "assert_macros.svh"

	localparam int ROW_W = $clog2(MAX_PATTERN + 1);

	cmd_t             cmd;
	status_t          status;
	logic [ROW_W-1:0] row;

	assign cfg_ready = 1'b1;

	asm_ctrl #(
		.MAX_PATTERN(MAX_PATTERN),
		.ROW_W(ROW_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_kind(item.kind),
		.item_stall(item_stall),
		.status(status),
		.cmd(cmd),
		.row(row)
	);

	asm_dp #(
		.MAX_PATTERN(MAX_PATTERN),
		.POS_BITS(POS_BITS),
		.ROW_W(ROW_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.row(row),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.status(status),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	`ASSERT_CLK(a_result_after_busy, clk, arst_n, $rose(result_valid) |-> $past(item_stall), "result appeared without a sweep")
	`ASSERT_CLK(a_start_busy, clk, arst_n, (item_valid && !item_stall && item.kind == KIND_START) |=> item_stall, "start text did not start a sweep")
	`ASSERT_CLK(a_dist_in_range, clk, arst_n, result_valid |-> (result.edit_distance <= status.max_distance), "reported distance above threshold")

endmodule
